// File: sv/sldr_pkg.sv
`timescale 1ns / 1ps
// Package for the slew-limited dead reckoning unit.
// Holds the CORDIC step count, scaling constants, the arctangent table and the sequencer states.
package sldr_pkg;

  localparam int CordicSteps = 16;

  localparam logic [19:0] AccelReset = 20'd256;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] QuarterTurn = 34'sd1073741824;
  localparam logic [34:0] ScaleDiv = 35'(64'd180 * 64'd60 * 64'd3600 * 64'd512);
  localparam logic [34:0] ScaleHalf = 35'((64'd180 * 64'd60 * 64'd3600 * 64'd512) / 2);

  // The scale is 2^17 times an odd factor; the division by the odd factor uses its
  // reciprocal scaled by 2^37.
  localparam logic [17:0] DivOdd = 18'(ScaleDiv >> 17);
  localparam logic [19:0] DivRecip = 20'((64'd1 << 37) / 64'(DivOdd));

  localparam logic [29:0] AtanTab [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MAXD,
    ST_SLEW,
    ST_PMUL,
    ST_CINIT,
    ST_CROT,
    ST_CDONE,
    ST_MLAT,
    ST_DINIT,
    ST_DQ1,
    ST_DR1,
    ST_DQ2,
    ST_DR2,
    ST_DFIX,
    ST_MHS,
    ST_MQ,
    ST_MLNG,
    ST_FIN
  } sldr_state_e;

endpackage

// File: sv/sldr_in_if.sv
`timescale 1ns / 1ps
// Input channel of the dead reckoning unit: one item per time tick.
// Stand-alone interface, no dependencies.
interface sldr_in_if;
  logic               valid;
  logic               ready;
  logic        [19:0] tick_length;
  logic signed [23:0] target_speed;
  logic        [15:0] heading;
  logic signed [31:0] latitude_in;
  logic signed [31:0] longitude_in;

  modport source (output valid, tick_length, target_speed, heading, latitude_in,
                  longitude_in, input ready);
  modport sink (input valid, tick_length, target_speed, heading, latitude_in,
                longitude_in, output ready);
endinterface

// File: sv/sldr_out_if.sv
`timescale 1ns / 1ps
// Result channel of the dead reckoning unit: new position and speed.
// Stand-alone interface, no dependencies.
interface sldr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] latitude_out;
  logic signed [31:0] longitude_out;
  logic signed [23:0] speed_now;

  modport source (output valid, latitude_out, longitude_out, speed_now, input ready);
  modport sink (input valid, latitude_out, longitude_out, speed_now, output ready);
endinterface

// File: sv/slew_limited_dead_reckoning_unit.sv
`timescale 1ns / 1ps
// Slew-limited dead reckoning top level with its sequencer and shared datapath.
// Depends on sldr_pkg, sldr_in_if and sldr_out_if.
//
// Each item is one time tick. The stored speed first slews toward the requested speed,
// then the position advances along the heading. One shared multiplier, one CORDIC
// rotator run twice (heading, then latitude) and a division by the fixed
// knot-to-angle scale (a shift by its power-of-two part, two rounds of reciprocal
// multiplication and back-multiplication, then a one-step correction) do all the work.
// The input is ready only while idle, so a new item is not taken before the last one is
// done. A new item is taken in the cycle after the result is registered, even while that
// result still waits on the output; the next result then holds in its last cycle until it
// is taken.
module slew_limited_dead_reckoning_unit
  import sldr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [19:0] cfg_wdata_i,
  sldr_in_if.sink     in_i,
  sldr_out_if.source  out_o
);

  sldr_state_e state_q, state_d;

  logic        [19:0] accel_q;
  logic signed [23:0] speed_q, speed_d;
  logic        [19:0] tick_q, tick_d;
  logic signed [23:0] target_q, target_d;
  logic        [15:0] head_q, head_d;
  logic signed [31:0] lat_q, lat_d;
  logic signed [31:0] lng_q, lng_d;
  logic        [23:0] maxd_q, maxd_d;
  logic signed [43:0] p_q, p_d;
  logic signed [61:0] prod_q, prod_d;
  logic signed [44:0] qv_q, qv_d;
  logic signed [33:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic               flip_q, flip_d;
  logic               csel_q, csel_d;
  logic               dsel_q, dsel_d;
  logic        [4:0]  step_q, step_d;
  logic signed [17:0] hc_q, hc_d, hs_q, hs_d, lc_q, lc_d;
  logic        [43:0] dnum_q, dnum_d;
  logic        [27:0] dq_q, dq_d;
  logic        [27:0] dql_q, dql_d;
  logic               dneg_q, dneg_d;
  logic signed [28:0] dlat_q, dlat_d;
  logic               ovalid_q, ovalid_d;
  logic signed [31:0] olat_q, olat_d, olng_q, olng_d;
  logic signed [23:0] ospd_q, ospd_d;

  logic signed [44:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [65:0] mul_p;
  logic signed [24:0] sdiff;
  logic        [24:0] smag;
  logic        [31:0] ang;
  logic signed [33:0] z0, zf;
  logic signed [33:0] dx, dy;
  logic signed [33:0] xr, yr;
  logic        [61:0] pmag;
  logic        [62:0] dsum;
  logic        [28:0] quo;
  logic signed [33:0] nlat;
  logic signed [61:0] qround;

  assign mul_p = mul_a * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MAXD: begin
        mul_a = 45'($unsigned(accel_q));
        mul_b = 21'($unsigned(tick_q));
      end
      ST_PMUL: begin
        mul_a = 45'(speed_q);
        mul_b = 21'($unsigned(tick_q));
      end
      ST_MLAT: begin
        mul_a = 45'(p_q);
        mul_b = 21'(hc_q);
      end
      ST_MHS: begin
        mul_a = 45'(p_q);
        mul_b = 21'(hs_q);
      end
      ST_MLNG: begin
        mul_a = qv_q;
        mul_b = 21'(lc_q);
      end
      ST_DQ1, ST_DQ2: begin
        mul_a = 45'(dnum_q);
        mul_b = 21'(DivRecip);
      end
      ST_DR1: begin
        mul_a = 45'(dq_q);
        mul_b = 21'(DivOdd);
      end
      ST_DR2: begin
        mul_a = 45'(dql_q);
        mul_b = 21'(DivOdd);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sdiff = 25'(target_q) - 25'(speed_q);
  assign smag = sdiff[24] ? 25'(-sdiff) : 25'(sdiff);

  assign ang = csel_q ? lat_q : {head_q, 16'd0};
  assign z0 = 34'($signed(ang));
  assign zf = 34'($signed(ang + 32'h8000_0000));
  assign dx = cy_q >>> step_q;
  assign dy = cx_q >>> step_q;
  assign xr = (cx_q + 34'sd8192) >>> 14;
  assign yr = (cy_q + 34'sd8192) >>> 14;

  assign pmag = prod_q[61] ? 62'(-prod_q) : 62'(prod_q);
  assign dsum = 63'(pmag) + 63'(ScaleHalf);
  assign quo = {1'b0, dq_q};
  assign qround = (prod_q + 62'sd32768) >>> 16;
  assign nlat = 34'(lat_q) + 34'(dlat_q);

  always_comb begin
    state_d  = state_q;
    speed_d  = speed_q;
    tick_d   = tick_q;
    target_d = target_q;
    head_d   = head_q;
    lat_d    = lat_q;
    lng_d    = lng_q;
    maxd_d   = maxd_q;
    p_d      = p_q;
    prod_d   = prod_q;
    qv_d     = qv_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    cz_d     = cz_q;
    flip_d   = flip_q;
    csel_d   = csel_q;
    dsel_d   = dsel_q;
    step_d   = step_q;
    hc_d     = hc_q;
    hs_d     = hs_q;
    lc_d     = lc_q;
    dnum_d   = dnum_q;
    dq_d     = dq_q;
    dql_d    = dql_q;
    dneg_d   = dneg_q;
    dlat_d   = dlat_q;
    ovalid_d = ovalid_q && !out_o.ready;
    olat_d   = olat_q;
    olng_d   = olng_q;
    ospd_d   = ospd_q;
    in_i.ready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          tick_d   = in_i.tick_length;
          target_d = in_i.target_speed;
          head_d   = in_i.heading;
          lat_d    = in_i.latitude_in;
          lng_d    = in_i.longitude_in;
          state_d  = ST_MAXD;
        end
      end
      ST_MAXD: begin
        maxd_d  = mul_p[39:16];
        state_d = ST_SLEW;
      end
      ST_SLEW: begin
        if (smag <= {1'b0, maxd_q}) begin
          speed_d = target_q;
        end else if (sdiff[24]) begin
          speed_d = speed_q - $signed(maxd_q);
        end else begin
          speed_d = speed_q + $signed(maxd_q);
        end
        state_d = ST_PMUL;
      end
      ST_PMUL: begin
        p_d     = mul_p[43:0];
        csel_d  = 1'b0;
        state_d = ST_CINIT;
      end
      ST_CINIT: begin
        cx_d   = CordicGain;
        cy_d   = '0;
        step_d = '0;
        if (z0 > QuarterTurn || z0 < -QuarterTurn) begin
          cz_d   = zf;
          flip_d = 1'b1;
        end else begin
          cz_d   = z0;
          flip_d = 1'b0;
        end
        state_d = ST_CROT;
      end
      ST_CROT: begin
        if (!cz_q[33]) begin
          cx_d = cx_q - dx;
          cy_d = cy_q + dy;
          cz_d = cz_q - 34'($unsigned(AtanTab[step_q]));
        end else begin
          cx_d = cx_q + dx;
          cy_d = cy_q - dy;
          cz_d = cz_q + 34'($unsigned(AtanTab[step_q]));
        end
        step_d = step_q + 5'd1;
        if (step_q == 5'(CordicSteps - 1)) begin
          state_d = ST_CDONE;
        end
      end
      ST_CDONE: begin
        if (!csel_q) begin
          hc_d    = flip_q ? 18'(-xr) : 18'(xr);
          hs_d    = flip_q ? 18'(-yr) : 18'(yr);
          csel_d  = 1'b1;
          state_d = ST_CINIT;
        end else begin
          lc_d    = flip_q ? 18'(-xr) : 18'(xr);
          state_d = ST_MLAT;
        end
      end
      ST_MLAT: begin
        prod_d  = mul_p[61:0];
        dsel_d  = 1'b0;
        state_d = ST_DINIT;
      end
      ST_DINIT: begin
        dneg_d  = prod_q[61];
        dnum_d  = dsum[60:17];
        state_d = ST_DQ1;
      end
      ST_DQ1: begin
        dq_d    = mul_p[64:37];
        state_d = ST_DR1;
      end
      ST_DR1: begin
        dnum_d  = dnum_q - mul_p[43:0];
        state_d = ST_DQ2;
      end
      ST_DQ2: begin
        dql_d   = mul_p[64:37];
        state_d = ST_DR2;
      end
      ST_DR2: begin
        dnum_d  = dnum_q - mul_p[43:0];
        dq_d    = dq_q + dql_q;
        state_d = ST_DFIX;
      end
      ST_DFIX: begin
        if (dnum_q >= 44'(DivOdd)) begin
          dq_d = dq_q + 28'd1;
        end
        state_d = dsel_q ? ST_FIN : ST_MHS;
      end
      ST_MHS: begin
        if (!dsel_q) begin
          dlat_d = dneg_q ? -$signed(quo) : $signed(quo);
        end
        prod_d  = mul_p[61:0];
        state_d = ST_MQ;
      end
      ST_MQ: begin
        qv_d    = qround[44:0];
        state_d = ST_MLNG;
      end
      ST_MLNG: begin
        prod_d  = mul_p[61:0];
        dsel_d  = 1'b1;
        state_d = ST_DINIT;
      end
      ST_FIN: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          if (nlat > QuarterTurn) begin
            olat_d = 32'(QuarterTurn);
          end else if (nlat < -QuarterTurn) begin
            olat_d = 32'(-QuarterTurn);
          end else begin
            olat_d = nlat[31:0];
          end
          olng_d  = lng_q + 32'(dneg_q ? -$signed(quo) : $signed(quo));
          ospd_d  = speed_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      accel_q  <= AccelReset;
      speed_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      speed_q  <= speed_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        accel_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tick_q   <= tick_d;
    target_q <= target_d;
    head_q   <= head_d;
    lat_q    <= lat_d;
    lng_q    <= lng_d;
    maxd_q   <= maxd_d;
    p_q      <= p_d;
    prod_q   <= prod_d;
    qv_q     <= qv_d;
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    cz_q     <= cz_d;
    flip_q   <= flip_d;
    csel_q   <= csel_d;
    dsel_q   <= dsel_d;
    step_q   <= step_d;
    hc_q     <= hc_d;
    hs_q     <= hs_d;
    lc_q     <= lc_d;
    dnum_q   <= dnum_d;
    dq_q     <= dq_d;
    dql_q    <= dql_d;
    dneg_q   <= dneg_d;
    dlat_q   <= dlat_d;
    olat_q   <= olat_d;
    olng_q   <= olng_d;
    ospd_q   <= ospd_d;
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.latitude_out  = olat_q;
  assign out_o.longitude_out = olng_q;
  assign out_o.speed_now     = ospd_q;

endmodule
